// File: hdl/gsm7u_pkg.sv
// shared types, constants and tables of the gsm 7-bit unpacker
package gsm7u_pkg;

  // output byte budget, one byte of it kept for a terminator
  localparam int TEXT_CAP = 512;
  localparam int CNT_W    = $clog2(TEXT_CAP);
  localparam int SUM_W    = CNT_W + 2;

  // token queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int CP_W = 16;

  localparam logic [6:0]      ESCAPE_CODE = 7'h1b;
  localparam logic [CP_W-1:0] CP_QMARK    = 16'h003f;
  localparam logic [CP_W-1:0] CP_ONE_MAX  = 16'h007f;
  localparam logic [CP_W-1:0] CP_TWO_MAX  = 16'h07ff;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SHORT    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // configuration register indexes
  localparam logic REG_SKIP_SEPTETS = 1'b0;
  localparam logic REG_SEPTET_COUNT = 1'b1;

  typedef struct packed {
    logic [7:0] packed_octet;
    logic       last_octet;
  } in_item_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       byte_valid;
    logic       end_of_text;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [7:0] skip_septets;
    logic [7:0] septet_count;
  } cfg_t;

  // one unit of work for the back end: a text septet or the end of a message
  typedef struct packed {
    logic       is_final;
    logic [6:0] septet;
    logic       at_end;
    logic       short_data;
  } token_t;

  localparam logic [CP_W-1:0] DEFAULT_ALPHA [0:127] = '{
    16'h0040, 16'h00a3, 16'h0024, 16'h00a5, 16'h00e8, 16'h00e9, 16'h00f9, 16'h00ec,
    16'h00f2, 16'h00c7, 16'h000a, 16'h00d8, 16'h00f8, 16'h000d, 16'h00c5, 16'h00e5,
    16'h0394, 16'h005f, 16'h03a6, 16'h0393, 16'h039b, 16'h03a9, 16'h03a0, 16'h03a8,
    16'h03a3, 16'h0398, 16'h039e, 16'h003f, 16'h00c6, 16'h00e6, 16'h00df, 16'h00c9,
    16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h00a4, 16'h0025, 16'h0026, 16'h0027,
    16'h0028, 16'h0029, 16'h002a, 16'h002b, 16'h002c, 16'h002d, 16'h002e, 16'h002f,
    16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
    16'h0038, 16'h0039, 16'h003a, 16'h003b, 16'h003c, 16'h003d, 16'h003e, 16'h003f,
    16'h00a1, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
    16'h0048, 16'h0049, 16'h004a, 16'h004b, 16'h004c, 16'h004d, 16'h004e, 16'h004f,
    16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
    16'h0058, 16'h0059, 16'h005a, 16'h00c4, 16'h00d6, 16'h00d1, 16'h00dc, 16'h00a7,
    16'h00bf, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
    16'h0068, 16'h0069, 16'h006a, 16'h006b, 16'h006c, 16'h006d, 16'h006e, 16'h006f,
    16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
    16'h0078, 16'h0079, 16'h007a, 16'h00e4, 16'h00f6, 16'h00f1, 16'h00fc, 16'h00e0
  };

  function automatic logic [CP_W-1:0] ext_codepoint(input logic [6:0] v);
    logic [CP_W-1:0] cp;
    case (v)
      7'h0a:   cp = 16'h000c;
      7'h14:   cp = 16'h005e;
      7'h28:   cp = 16'h007b;
      7'h29:   cp = 16'h007d;
      7'h2f:   cp = 16'h005c;
      7'h3c:   cp = 16'h005b;
      7'h3d:   cp = 16'h007e;
      7'h3e:   cp = 16'h005d;
      7'h40:   cp = 16'h007c;
      7'h65:   cp = 16'h20ac;
      default: cp = CP_QMARK;
    endcase
    return cp;
  endfunction

endpackage

// File: hdl/gsm7u_front.sv
// front end: bit unpacking, header skip and message end tokens
module gsm7u_front import gsm7u_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  input  logic     queue_full_i,
  output logic     push_o,
  output token_t   push_tok_o
);

  logic [13:0] buf_q, buf_d, buf_v;
  logic [3:0]  held_q, held_d, held_v;
  logic [8:0]  seen_q, seen_d;
  logic        last_q, last_d, last_v;
  logic [8:0]  needed;
  logic        in_acc;
  logic        more_text;
  logic        want_push;
  logic        advance;
  logic        at_end;

  assign needed    = {1'b0, cfg_i.skip_septets} + {1'b0, cfg_i.septet_count};
  assign more_text = seen_q < needed;
  assign at_end    = ({1'b0, seen_q} + 10'd1) >= {1'b0, needed};

  // work still queued from the last octet holds off the next one
  assign in_stall_o = ((held_q >= 4'd7) && more_text) || last_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    buf_v  = buf_q;
    held_v = held_q;
    last_v = last_q;
    if (in_acc) begin
      last_v = in_data_i.last_octet;
      if (more_text) begin
        buf_v  = buf_q | (14'(in_data_i.packed_octet) << held_q);
        held_v = held_q + 4'd8;
      end
    end
  end

  always_comb begin
    buf_d      = buf_v;
    held_d     = held_v;
    seen_d     = seen_q;
    last_d     = last_v;
    want_push  = 1'b0;
    push_tok_o = '0;
    push_tok_o.septet = buf_v[6:0];
    push_tok_o.at_end = at_end;
    if ((held_v >= 4'd7) && more_text) begin
      want_push = seen_q >= {1'b0, cfg_i.skip_septets};
      advance   = !want_push || !queue_full_i;
      if (advance) begin
        buf_d  = buf_v >> 7;
        held_d = held_v - 4'd7;
        seen_d = seen_q + 9'd1;
      end
    end else if (last_v) begin
      if (more_text && (held_v != 4'd0)) begin
        // partial septet, missing high bits are zero
        want_push = seen_q >= {1'b0, cfg_i.skip_septets};
        advance   = !want_push || !queue_full_i;
        if (advance) begin
          buf_d  = '0;
          held_d = '0;
          seen_d = seen_q + 9'd1;
        end
      end else begin
        want_push             = 1'b1;
        push_tok_o.is_final   = 1'b1;
        push_tok_o.short_data = (cfg_i.septet_count != 8'd0) && more_text;
        advance               = !queue_full_i;
        if (advance) begin
          buf_d  = '0;
          held_d = '0;
          seen_d = '0;
          last_d = 1'b0;
        end
      end
    end else begin
      advance = 1'b0;
    end
  end

  assign push_o = want_push && !queue_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= '0;
      held_q <= '0;
      seen_q <= '0;
      last_q <= 1'b0;
    end else begin
      buf_q  <= buf_d;
      held_q <= held_d;
      seen_q <= seen_d;
      last_q <= last_d;
    end
  end

endmodule

// File: hdl/gsm7u_fifo.sv
// short token queue between front and back end
module gsm7u_fifo import gsm7u_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  token_t push_tok_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output token_t head_o
);

  token_t                entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]     fill_q;

  assign full_o  = fill_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign empty_o = fill_q == '0;
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + (QUEUE_AW+1)'(1);
        2'b01:   fill_q <= fill_q - (QUEUE_AW+1)'(1);
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

// File: hdl/gsm7u_back.sv
// back end: alphabet mapping, utf-8 byte sequencing, capacity and status
module gsm7u_back import gsm7u_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      tok_empty_i,
  input  token_t    tok_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  out_item_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       b1_q, b1_d, b2_q, b2_d;
  logic [1:0]       rem_q, rem_d;
  logic             esc_q, esc_d;
  logic             err_q, err_d;
  logic [CNT_W-1:0] bytes_q, bytes_d;

  logic             out_free;
  logic             esc_start;
  logic [CP_W-1:0]  cp;
  logic [1:0]       len;
  logic [SUM_W-1:0] sum;
  logic             fits;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign esc_start = !esc_q && (tok_i.septet == ESCAPE_CODE);

  always_comb begin
    if (esc_q) begin
      cp = ext_codepoint(tok_i.septet);
    end else if (esc_start) begin
      cp = CP_QMARK;  // escape as final text septet
    end else begin
      cp = DEFAULT_ALPHA[tok_i.septet];
    end
    if (cp <= CP_ONE_MAX) begin
      len = 2'd1;
    end else if (cp <= CP_TWO_MAX) begin
      len = 2'd2;
    end else begin
      len = 2'd3;
    end
  end

  assign sum  = SUM_W'(bytes_q) + SUM_W'(len);
  assign fits = sum < SUM_W'(TEXT_CAP);

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    b1_d        = b1_q;
    b2_d        = b2_q;
    rem_d       = rem_q;
    esc_d       = esc_q;
    err_d       = err_q;
    bytes_d     = bytes_q;
    pop_o       = 1'b0;
    if (out_free) begin
      out_valid_d = 1'b0;
      if (rem_q != 2'd0) begin
        out_d       = '{utf8_byte: b1_q, byte_valid: 1'b1, end_of_text: 1'b0,
                        status: STATUS_OK};
        out_valid_d = 1'b1;
        b1_d        = b2_q;
        rem_d       = rem_q - 2'd1;
      end else if (!tok_empty_i) begin
        pop_o = 1'b1;
        if (tok_i.is_final) begin
          out_d.utf8_byte   = 8'd0;
          out_d.byte_valid  = 1'b0;
          out_d.end_of_text = 1'b1;
          if (err_q) begin
            out_d.status = STATUS_OVERFLOW;
          end else if (tok_i.short_data) begin
            out_d.status = STATUS_SHORT;
          end else begin
            out_d.status = STATUS_OK;
          end
          out_valid_d = 1'b1;
          esc_d       = 1'b0;
          err_d       = 1'b0;
          bytes_d     = '0;
        end else if (!err_q) begin
          if (esc_start && !tok_i.at_end) begin
            esc_d = 1'b1;
          end else begin
            esc_d = 1'b0;
            if (fits) begin
              bytes_d           = bytes_q + CNT_W'(len);
              out_d.byte_valid  = 1'b1;
              out_d.end_of_text = 1'b0;
              out_d.status      = STATUS_OK;
              out_valid_d       = 1'b1;
              rem_d             = len - 2'd1;
              case (len)
                2'd1: begin
                  out_d.utf8_byte = cp[7:0];
                end
                2'd2: begin
                  out_d.utf8_byte = {3'b110, cp[10:6]};
                  b1_d            = {2'b10, cp[5:0]};
                end
                default: begin
                  out_d.utf8_byte = {4'b1110, cp[15:12]};
                  b1_d            = {2'b10, cp[11:6]};
                  b2_d            = {2'b10, cp[5:0]};
                end
              endcase
            end else begin
              err_d = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    b1_q  <= b1_d;
    b2_q  <= b2_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rem_q       <= '0;
      esc_q       <= 1'b0;
      err_q       <= 1'b0;
      bytes_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
      esc_q       <= esc_d;
      err_q       <= err_d;
      bytes_q     <= bytes_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/gsm7_septet_unpack_to_utf8.sv
// top level of the gsm 7-bit septet unpacker with utf-8 output
//
//  channel   direction  handshake                payload
//  in        input      in_valid_i / in_stall_o  in_data_i: packed_octet, last_octet
//  out       output     out_valid_o/ out_stall_i out_data_o: utf8_byte, byte_valid,
//                                                end_of_text, status
//  cfg       input      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// the front cuts one septet, or closes one message, per cycle unless a full token
// queue holds it, starting in the cycle an octet beat is taken; an octet beat
// holds the input until every step it brings is done: each septet it completes
// and, on a last octet, its partial septet and the closing token
// the back end retires one queued septet per cycle and sends one utf-8 byte per
// cycle unless the output stalls; a multi-byte septet holds it until its last
// byte is sent; mostly ascii text settles at about 1.14 output beats per octet beat
// a four-entry token queue lets the front keep unpacking while the output stalls
// asynchronous active-low reset clears all message state and both registers

module gsm7_septet_unpack_to_utf8 import gsm7u_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  // configuration writes
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  // packed octet beats
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  // utf-8 byte and status beats
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  cfg_t   cfg_q;
  logic   queue_full;
  logic   queue_empty;
  logic   push;
  logic   pop;
  token_t push_tok;
  token_t head_tok;

  // register file; the user must write it only between messages, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SKIP_SEPTETS: cfg_q.skip_septets <= cfg_wdata_i;
        REG_SEPTET_COUNT: cfg_q.septet_count <= cfg_wdata_i;
        default:          cfg_q <= cfg_q;
      endcase
    end
  end

  // front: septet cutting, header skip, end-of-message token
  gsm7u_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_tok_o   (push_tok)
  );

  // decouples octet intake from byte output
  gsm7u_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_tok_i (push_tok),
    .full_o     (queue_full),
    .pop_i      (pop),
    .empty_o    (queue_empty),
    .head_o     (head_tok)
  );

  // back: escape handling, alphabet lookup, utf-8 bytes, capacity, status
  gsm7u_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_empty_i (queue_empty),
    .tok_i       (head_tok),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: hdl/gsm7u_checker.sv
// port-level checks of the gsm 7-bit unpacker, bound to its top level
module gsm7u_checker import gsm7u_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // a stalled output beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // handshake outputs are always driven to known levels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_stall_o, out_valid_o}))
    else $error("unknown handshake output");

  // text beats carry no status and never close the message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_valid |->
      !out_data_o.end_of_text && (out_data_o.status == STATUS_OK))
    else $error("text beat with status or end mark");

  // a status-only beat is the closing beat, with a zero byte and a known code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |->
      out_data_o.end_of_text && (out_data_o.utf8_byte == 8'd0) &&
      (out_data_o.status != 2'd3))
    else $error("malformed closing beat");

endmodule

bind gsm7_septet_unpack_to_utf8 gsm7u_checker u_checker (.*);
